// ----- sv/cirbs_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cirbs_pkg
// Shared widths, codes and the byte folding function of the record search.
// ============================================================================
package cirbs_pkg;

  localparam int ValueW   = 64;  // width of a record or search key
  localparam int BytesMax = 8;   // bytes in one record value
  localparam int IndexW   = 8;   // width of the table position field
  localparam int LenW     = 4;   // record_length register width
  localparam int CountW   = 9;   // record_count register width
  localparam int CfgDataW = 9;   // widest configuration register
  localparam int CfgIdxW  = 1;   // configuration register index width

  // Command codes.
  localparam logic CmdStore  = 1'b0;
  localparam logic CmdSearch = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRecordLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRecordCount  = 1'b1;

  // Folds ASCII upper case to lower case in the first len bytes and clears
  // the bytes beyond them. Unsigned order of the result is the bytewise
  // lexicographic order of the folded prefix.
  function automatic logic [ValueW-1:0] fold_mask(input logic [ValueW-1:0] v,
                                                  input logic [LenW-1:0] len);
    logic [ValueW-1:0] r;
    logic [7:0]        b;
    r = '0;
    for (int i = 0; i < BytesMax; i++) begin
      b = v[ValueW-1-8*i -: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b + 8'h20;
      end
      if (LenW'(i) < len) begin
        r[ValueW-1-8*i -: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/cirbs_req_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cirbs_req_if
// Request channel: store a record or search for a key.
// ============================================================================
interface cirbs_req_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [cirbs_pkg::IndexW-1:0]   entry_index;
  logic [cirbs_pkg::ValueW-1:0]   record_value;

  modport source (output valid, command, entry_index, record_value, input ready);
  modport sink   (input valid, command, entry_index, record_value, output ready);
endinterface

// ----- sv/cirbs_rsp_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cirbs_rsp_if
// Response channel: one found flag per search.
// ============================================================================
interface cirbs_rsp_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

// ----- sv/case_insensitive_record_binary_search_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// case_insensitive_record_binary_search_unit
// Table of fixed-length text records with a case-insensitive binary search.
// ============================================================================
//
//  Channel  Direction  Payload                               Per item
//  -------  ---------  ------------------------------------  -------------------
//  req_i    in         command, entry_index, record_value    store or search
//  rsp_o    out        found                                 one per search
//  cfg      in         cfg_index_i, cfg_wdata_i              register write
//
// A store item is written when accepted and leaves the unit ready. A search
// item issues its first probe in its accept cycle and makes at most
// floor(log2(count)) + 1 probes, each waiting for one registered read from
// the single memory read port; no new item is taken until the search ends.
// Reset clears the control state only; the record memory has no reset and no
// clearing pass. A stalled response blocks new items only once a second
// search result is ready while the first is still waiting.
//
module case_insensitive_record_binary_search_unit #(
  parameter int MAX_RECORDS      = 256,
  parameter int MAX_RECORD_BYTES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cirbs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cirbs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  cirbs_req_if.sink                        req_i,
  cirbs_rsp_if.source                      rsp_o
);
  import cirbs_pkg::*;

  // Address width of the table, bound width (0..MAX_RECORDS) and the
  // number of record bits actually kept in the memory.
  localparam int AddrW = $clog2(MAX_RECORDS);
  localparam int BndW  = $clog2(MAX_RECORDS + 1);
  localparam int RecW  = 8 * MAX_RECORD_BYTES;
  localparam int PadW  = ValueW - RecW;

  typedef enum logic [1:0] {
    StIdle,
    StProbe,
    StHold
  } state_e;

  // Configuration registers.
  logic [LenW-1:0]   len_cfg_q;
  logic [CountW-1:0] cnt_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LenW'(8);
      cnt_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRecordLength: len_cfg_q <= cfg_wdata_i[LenW-1:0];
        CfgRecordCount:  cnt_cfg_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Control and search state. The search keeps low and high+1, so the
  // interval is empty exactly when low is no longer below high+1.
  state_e          state_q, state_d;
  logic [BndW-1:0] low_q, low_d;
  logic [BndW-1:0] hp1_q, hp1_d;
  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;

  // Per-search payload registers.
  logic [ValueW-1:0] key_q, key_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [AddrW-1:0]  mid_q, mid_d;
  logic              pend_q, pend_d;

  // Record memory with one write or one read per cycle.
  logic [RecW-1:0]  mem [MAX_RECORDS];
  logic [RecW-1:0]  rd_data_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= req_i.record_value[ValueW-1 -: RecW];
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // Request decode.
  logic            req_fire;
  logic            is_search;
  logic [LenW-1:0] eff_len;
  logic [BndW-1:0] eff_cnt;
  logic            idx_ok;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_search   = (req_i.command == CmdSearch);
  assign idx_ok      = (32'(req_i.entry_index) < 32'(MAX_RECORDS));

  // Out-of-range lengths and counts are clamped to the legal range.
  always_comb begin
    if (len_cfg_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(len_cfg_q) > 32'(MAX_RECORD_BYTES)) begin
      eff_len = LenW'(MAX_RECORD_BYTES);
    end else begin
      eff_len = len_cfg_q;
    end
    if (32'(cnt_cfg_q) > 32'(MAX_RECORDS)) begin
      eff_cnt = BndW'(MAX_RECORDS);
    end else begin
      eff_cnt = BndW'(32'(cnt_cfg_q));
    end
  end

  assign mem_we    = req_fire && !is_search && idx_ok;
  assign mem_waddr = AddrW'(32'(req_i.entry_index));

  // Probe compare on the word read in the previous cycle.
  logic [ValueW-1:0] probe_key;
  logic              probe_eq, probe_lt;
  logic [BndW-1:0]   low_n, hp1_n;
  logic [BndW:0]     mid_sum;

  assign probe_key = fold_mask(ValueW'(rd_data_q) << PadW, len_q);
  assign probe_eq  = (probe_key == key_q);
  assign probe_lt  = (probe_key < key_q);
  assign low_n     = probe_lt ? BndW'(mid_q) + BndW'(1) : low_q;
  assign hp1_n     = probe_lt ? hp1_q : BndW'(mid_q);

  // Result and output register handling.
  logic res_fire, res_val, out_free;

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    hp1_d       = hp1_q;
    key_d       = key_q;
    len_d       = len_q;
    mid_d       = mid_q;
    pend_d      = pend_q;
    mem_re      = 1'b0;
    mem_raddr   = mid_q;
    mid_sum     = '0;
    res_fire    = 1'b0;
    res_val     = 1'b0;

    case (state_q)
      StIdle: begin
        if (req_fire && is_search) begin
          key_d = fold_mask(req_i.record_value, eff_len);
          len_d = eff_len;
          low_d = '0;
          hp1_d = eff_cnt;
          if (eff_cnt == '0) begin
            res_fire = 1'b1;
            res_val  = 1'b0;
          end else begin
            // First probe is issued in the accept cycle.
            mid_sum   = ({1'b0, eff_cnt} - (BndW+1)'(1)) >> 1;
            mid_d     = AddrW'(mid_sum);
            mem_re    = 1'b1;
            mem_raddr = mid_d;
            state_d   = StProbe;
          end
        end
      end
      StProbe: begin
        low_d = low_n;
        hp1_d = hp1_n;
        if (probe_eq) begin
          res_fire = 1'b1;
          res_val  = 1'b1;
        end else if (low_n < hp1_n) begin
          mid_sum   = ({1'b0, low_n} + {1'b0, hp1_n} - (BndW+1)'(1)) >> 1;
          mid_d     = AddrW'(mid_sum);
          mem_re    = 1'b1;
          mem_raddr = mid_d;
        end else begin
          res_fire = 1'b1;
          res_val  = 1'b0;
        end
      end
      StHold: begin
        res_fire = 1'b1;
        res_val  = pend_q;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A finished result goes to the output register when it is free, and
    // otherwise waits in the hold state.
    out_valid_d = out_valid_q && !rsp_o.ready;
    found_d     = found_q;
    if (res_fire) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        found_d     = res_val;
        state_d     = StIdle;
      end else begin
        pend_d  = res_val;
        state_d = StHold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      low_q       <= '0;
      hp1_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      hp1_q       <= hp1_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    len_q  <= len_d;
    mid_q  <= mid_d;
    pend_q <= pend_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.found = found_q;

endmodule
